// ===== hw/rtl/rsi_pkg.sv =====
`default_nettype none

package rsi_pkg;

    // fraction bits of every fixed-point field
    localparam int FRAC_BITS = 16;

    localparam int FIELD_W = 32;
    localparam int RAD_W   = 31;
    localparam int DIST_W  = 31;

    // m = origin - center, products and sums kept exact
    localparam int M_W  = FIELD_W + 1;
    localparam int PB_W = M_W + FIELD_W;
    localparam int PM_W = 2 * M_W;
    localparam int RR_W = 2 * RAD_W;
    localparam int B_W  = PB_W + 2;
    localparam int C_W  = PM_W + 2;

    // b*b is built from two halves of |b|
    localparam int ABSB_W = B_W - 1;
    localparam int LO_W   = (ABSB_W + 1) / 2;
    localparam int HI_W   = ABSB_W - LO_W;
    localparam int BSQ_W  = 2 * ABSB_W;

    // discriminant b*b - (c << 2F), width rounded up to even for the root
    localparam int CSH_W    = C_W + 2 * FRAC_BITS;
    localparam int DISC_RAW = ((BSQ_W > CSH_W) ? BSQ_W : CSH_W) + 1;
    localparam int DISC_W   = DISC_RAW + (DISC_RAW % 2);
    localparam int ROOT_W   = DISC_W / 2;
    localparam int REM_W    = ROOT_W + 2;

    // t = -b - root
    localparam int T_W = ((B_W > ROOT_W) ? B_W : ROOT_W) + 2;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] origin_x;
        logic signed [FIELD_W-1:0] origin_y;
        logic signed [FIELD_W-1:0] origin_z;
        logic signed [FIELD_W-1:0] dir_x;
        logic signed [FIELD_W-1:0] dir_y;
        logic signed [FIELD_W-1:0] dir_z;
        logic signed [FIELD_W-1:0] center_x;
        logic signed [FIELD_W-1:0] center_y;
        logic signed [FIELD_W-1:0] center_z;
        logic        [RAD_W-1:0]   radius;
    } ray_beat_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } res_beat_t;

    // what rides alongside the square root
    typedef struct packed {
        logic                  ok;
        logic signed [B_W-1:0] b;
    } rsi_side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsi_sqrt_pipe.sv =====
`default_nettype none

module rsi_sqrt_pipe (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              adv,
    input  wire                              in_valid,
    input  wire  [rsi_pkg::DISC_W-1:0]       in_x,
    input  rsi_pkg::rsi_side_t               in_side,
    output logic                             out_valid,
    output logic [rsi_pkg::ROOT_W-1:0]       out_root,
    output rsi_pkg::rsi_side_t               out_side
);

    localparam int NSTG = rsi_pkg::ROOT_W;

    logic                        vld_reg  [NSTG];
    logic [rsi_pkg::DISC_W-1:0]  x_reg    [NSTG];
    logic [rsi_pkg::REM_W-1:0]   rem_reg  [NSTG];
    logic [rsi_pkg::ROOT_W-1:0]  root_reg [NSTG];
    rsi_pkg::rsi_side_t          side_reg [NSTG];

    logic [rsi_pkg::DISC_W-1:0]  x_next    [NSTG];
    logic [rsi_pkg::REM_W-1:0]   rem_next  [NSTG];
    logic [rsi_pkg::ROOT_W-1:0]  root_next [NSTG];

    logic [rsi_pkg::DISC_W-1:0]  stage_x;
    logic [rsi_pkg::REM_W-1:0]   stage_rem;
    logic [rsi_pkg::ROOT_W-1:0]  stage_root;
    logic [rsi_pkg::REM_W+1:0]   cand;
    logic [rsi_pkg::REM_W+1:0]   trial;
    logic                        fits;

    // one result bit per stage: bring down two bits, try (root << 2) | 1
    always_comb
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            if (i == 0)
            begin
                stage_x    = in_x;
                stage_rem  = '0;
                stage_root = '0;
            end
            else
            begin
                stage_x    = x_reg[i-1];
                stage_rem  = rem_reg[i-1];
                stage_root = root_reg[i-1];
            end
            cand  = {stage_rem, stage_x[rsi_pkg::DISC_W-1 -: 2]};
            trial = (rsi_pkg::REM_W + 2)'({stage_root, 2'b01});
            fits  = (cand >= trial);
            x_next[i]    = stage_x << 2;
            rem_next[i]  = fits ? rsi_pkg::REM_W'(cand - trial) : rsi_pkg::REM_W'(cand);
            root_next[i] = {stage_root[rsi_pkg::ROOT_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            for (int i = 1; i < NSTG; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 0; i < NSTG; i++)
            begin
                x_reg[i]    <= x_next[i];
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_root  = root_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

`default_nettype wire

// ===== hw/rtl/ray_sphere_intersect.sv =====
// Ray/sphere hit test, one ray per clock while ray_ready is high. A beat on ray_data
// carries origin, direction (taken as unit length) and sphere center in signed Q16.16
// and radius in unsigned Q15.16; one beat on res_data comes back for each, in order:
// hit and the distance to the near surface, 0 when the origin is inside, saturated at
// the largest Q16.16 value, and 0 on a miss. The pipeline has 7 stages of differences,
// products and the discriminant, 67 stages of the bit-per-stage square root, one stage
// for the distance, and the output register. A two-beat output buffer sits behind the
// pipeline; ray_ready drops only while that buffer is full, so a stalled consumer
// freezes the whole pipeline without losing or repeating a beat.
`default_nettype none

module ray_sphere_intersect (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 ray_valid,
    output logic                ray_ready,
    input  rsi_pkg::ray_beat_t  ray_data,
    output logic                res_valid,
    input  wire                 res_ready,
    output rsi_pkg::res_beat_t  res_data
);

    localparam logic [1:0] SKID_EMPTY = 2'd0;
    localparam logic [1:0] SKID_ONE   = 2'd1;
    localparam logic [1:0] SKID_FULL  = 2'd2;

    logic adv;

    // stage 1: m = origin - center
    logic signed [rsi_pkg::FIELD_W-1:0] org [3];
    logic signed [rsi_pkg::FIELD_W-1:0] dir [3];
    logic signed [rsi_pkg::FIELD_W-1:0] ctr [3];

    logic                               s1_vld_reg;
    logic signed [rsi_pkg::M_W-1:0]     m_reg   [3];
    logic signed [rsi_pkg::FIELD_W-1:0] dir_reg [3];
    logic        [rsi_pkg::RAD_W-1:0]   rad_reg;

    // stage 2: products
    logic                               s2_vld_reg;
    logic signed [rsi_pkg::PB_W-1:0]    pb_reg [3];
    logic signed [rsi_pkg::PM_W-1:0]    pm_reg [3];
    logic        [rsi_pkg::RR_W-1:0]    rr_reg;

    // stage 3: b and c
    logic                               s3_vld_reg;
    logic signed [rsi_pkg::B_W-1:0]     b3_reg;
    logic signed [rsi_pkg::C_W-1:0]     c3_reg;

    // stage 4: |b| and the pointing-away test
    logic                               s4_vld_reg;
    logic        [rsi_pkg::ABSB_W-1:0]  absb_reg;
    logic signed [rsi_pkg::B_W-1:0]     b4_reg;
    logic signed [rsi_pkg::C_W-1:0]     c4_reg;
    logic                               far4_reg;

    // stage 5: partial products of b*b
    logic                               s5_vld_reg;
    logic [2*rsi_pkg::HI_W-1:0]         phh_reg;
    logic [rsi_pkg::HI_W+rsi_pkg::LO_W-1:0] phl_reg;
    logic [2*rsi_pkg::LO_W-1:0]         pll_reg;
    logic signed [rsi_pkg::B_W-1:0]     b5_reg;
    logic signed [rsi_pkg::C_W-1:0]     c5_reg;
    logic                               far5_reg;

    // stage 6: b*b
    logic                               s6_vld_reg;
    logic [rsi_pkg::BSQ_W-1:0]          bsq_reg;
    logic signed [rsi_pkg::B_W-1:0]     b6_reg;
    logic signed [rsi_pkg::C_W-1:0]     c6_reg;
    logic                               far6_reg;

    // stage 7: discriminant
    logic signed [rsi_pkg::DISC_W-1:0]  disc;
    logic                               s7_vld_reg;
    logic [rsi_pkg::DISC_W-1:0]         x7_reg;
    rsi_pkg::rsi_side_t                 side7_reg;

    // square root
    logic                               sq_vld;
    logic [rsi_pkg::ROOT_W-1:0]         sq_root;
    rsi_pkg::rsi_side_t                 sq_side;

    // stage 8: t = -b - root
    logic                               s8_vld_reg;
    logic signed [rsi_pkg::T_W-1:0]     t_reg;
    logic                               ok8_reg;
    logic [rsi_pkg::T_W-1:0]            t_shift;
    rsi_pkg::res_beat_t                 res_new;

    // output buffer
    logic [1:0]                         cnt_reg;
    logic [1:0]                         cnt_next;
    rsi_pkg::res_beat_t                 head_reg;
    rsi_pkg::res_beat_t                 head_next;
    rsi_pkg::res_beat_t                 tail_reg;
    rsi_pkg::res_beat_t                 tail_next;
    logic                               push;
    logic                               pop;

    assign adv       = (cnt_reg != SKID_FULL);
    assign ray_ready = adv;

    assign org[0] = ray_data.origin_x;
    assign org[1] = ray_data.origin_y;
    assign org[2] = ray_data.origin_z;
    assign dir[0] = ray_data.dir_x;
    assign dir[1] = ray_data.dir_y;
    assign dir[2] = ray_data.dir_z;
    assign ctr[0] = ray_data.center_x;
    assign ctr[1] = ray_data.center_y;
    assign ctr[2] = ray_data.center_z;

    assign disc = $signed(rsi_pkg::DISC_W'(bsq_reg))
                - (rsi_pkg::DISC_W'(c6_reg) << (2 * rsi_pkg::FRAC_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= ray_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_reg[k]   <= rsi_pkg::M_W'(org[k]) - rsi_pkg::M_W'(ctr[k]);
                dir_reg[k] <= dir[k];
                pb_reg[k]  <= m_reg[k] * dir_reg[k];
                pm_reg[k]  <= m_reg[k] * m_reg[k];
            end
            rad_reg <= ray_data.radius;
            rr_reg  <= rsi_pkg::RR_W'(rad_reg) * rsi_pkg::RR_W'(rad_reg);

            b3_reg <= rsi_pkg::B_W'(pb_reg[0]) + rsi_pkg::B_W'(pb_reg[1])
                    + rsi_pkg::B_W'(pb_reg[2]);
            c3_reg <= rsi_pkg::C_W'(pm_reg[0]) + rsi_pkg::C_W'(pm_reg[1])
                    + rsi_pkg::C_W'(pm_reg[2]) - $signed(rsi_pkg::C_W'(rr_reg));

            absb_reg <= rsi_pkg::ABSB_W'(b3_reg[rsi_pkg::B_W-1] ? -b3_reg : b3_reg);
            b4_reg   <= b3_reg;
            c4_reg   <= c3_reg;
            // origin outside and ray pointing away
            far4_reg <= !c3_reg[rsi_pkg::C_W-1] && (c3_reg != '0)
                     && !b3_reg[rsi_pkg::B_W-1] && (b3_reg != '0);

            phh_reg  <= (2*rsi_pkg::HI_W)'(absb_reg[rsi_pkg::ABSB_W-1:rsi_pkg::LO_W])
                      * (2*rsi_pkg::HI_W)'(absb_reg[rsi_pkg::ABSB_W-1:rsi_pkg::LO_W]);
            phl_reg  <= (rsi_pkg::HI_W+rsi_pkg::LO_W)'(absb_reg[rsi_pkg::ABSB_W-1:rsi_pkg::LO_W])
                      * (rsi_pkg::HI_W+rsi_pkg::LO_W)'(absb_reg[rsi_pkg::LO_W-1:0]);
            pll_reg  <= (2*rsi_pkg::LO_W)'(absb_reg[rsi_pkg::LO_W-1:0])
                      * (2*rsi_pkg::LO_W)'(absb_reg[rsi_pkg::LO_W-1:0]);
            b5_reg   <= b4_reg;
            c5_reg   <= c4_reg;
            far5_reg <= far4_reg;

            bsq_reg  <= (rsi_pkg::BSQ_W'(phh_reg) << (2 * rsi_pkg::LO_W))
                      + (rsi_pkg::BSQ_W'(phl_reg) << (rsi_pkg::LO_W + 1))
                      + rsi_pkg::BSQ_W'(pll_reg);
            b6_reg   <= b5_reg;
            c6_reg   <= c5_reg;
            far6_reg <= far5_reg;

            // a miss feeds zero to the root, the result is dropped later
            side7_reg.ok <= !far6_reg && !disc[rsi_pkg::DISC_W-1];
            side7_reg.b  <= b6_reg;
            x7_reg       <= (far6_reg || disc[rsi_pkg::DISC_W-1]) ? '0 : disc;

            t_reg   <= -rsi_pkg::T_W'(sq_side.b) - $signed(rsi_pkg::T_W'(sq_root));
            ok8_reg <= sq_side.ok;
        end
    end

    rsi_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s7_vld_reg),
        .in_x      (x7_reg),
        .in_side   (side7_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign t_shift = t_reg >> rsi_pkg::FRAC_BITS;

    always_comb
    begin
        res_new.hit      = ok8_reg;
        res_new.distance = '0;
        if (ok8_reg && !t_reg[rsi_pkg::T_W-1])
        begin
            if (t_shift[rsi_pkg::T_W-1:rsi_pkg::DIST_W] != '0)
            begin
                res_new.distance = rsi_pkg::DIST_MAX;
            end
            else
            begin
                res_new.distance = t_shift[rsi_pkg::DIST_W-1:0];
            end
        end
    end

    assign push = adv && s8_vld_reg;
    assign pop  = res_valid && res_ready;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (push && !pop)
        begin
            if (cnt_reg == SKID_EMPTY)
            begin
                head_next = res_new;
            end
            else
            begin
                tail_next = res_new;
            end
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
        else if (pop && push)
        begin
            if (cnt_reg == SKID_ONE)
            begin
                head_next = res_new;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = res_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= SKID_EMPTY;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign res_valid = (cnt_reg != SKID_EMPTY);
    assign res_data  = head_reg;

    // a miss never reports a distance
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.hit |-> res_data.distance == '0)
        else $error("miss beat with nonzero distance");

    // the output buffer never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == SKID_EMPTY || cnt_reg == SKID_ONE || cnt_reg == SKID_FULL)
        else $error("output buffer count out of range");

    // a frozen pipeline holds its last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv && s8_vld_reg |=> s8_vld_reg && $stable(t_reg) && $stable(ok8_reg))
        else $error("distance stage changed while stalled");

    // a full buffer stays full until the consumer takes a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == SKID_FULL && !res_ready |=> cnt_reg == SKID_FULL && $stable(head_reg))
        else $error("output buffer lost a beat while stalled");

endmodule

`default_nettype wire
